### src/quoted_string_unescape_utf8_assert.svh
// ---------------------------------------------------------------------------
// Quoted string unescaper assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef QUOTED_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define QUOTED_STRING_UNESCAPE_UTF8_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QSU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/qsu_pkg.sv
// ---------------------------------------------------------------------------
// Quoted string unescaper package
// Types, codes and constants shared by the unescaper modules.
// ---------------------------------------------------------------------------
package qsu_pkg;

    localparam int ESCAPE_SLOTS = 8;
    localparam int CFG_DATA_W   = 64;

    localparam logic [0:0] CFG_ESCAPE_COUNT = 1'b0;
    localparam logic [0:0] CFG_ESCAPE_CHARS = 1'b1;

    localparam logic [3:0]            ESCAPE_COUNT_RESET = 4'd7;
    localparam logic [CFG_DATA_W-1:0] ESCAPE_CHARS_RESET = 64'd33060607102444079;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_STRING,
        PH_BACKSLASH,
        PH_UNICODE
    } phase_t;

    typedef enum logic [2:0] {
        ST_BYTE,
        ST_DONE,
        ST_NOT_STRING,
        ST_CONTROL,
        ST_BAD_HEX,
        ST_SURROGATE,
        ST_UNTERMINATED,
        ST_TRUNCATED
    } status_t;

    typedef struct packed {
        logic [7:0] out_byte;
        status_t    status;
    } result_t;

    // Results caused by one input byte, slot 0 delivered first.
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     slot;
    } group_t;

endpackage

### src/qsu_decode.sv
// ---------------------------------------------------------------------------
// Quoted string unescaper byte decoder
// Computes the next scanner state and the result group for one text byte.
// ---------------------------------------------------------------------------
module qsu_decode (
    input  logic [7:0]                    text_byte,
    input  logic                          final_byte,
    input  qsu_pkg::phase_t               phase,
    input  logic [1:0]                    hex_seen,
    input  logic [15:0]                   code_point,
    input  logic [3:0]                    escape_count,
    input  logic [qsu_pkg::CFG_DATA_W-1:0] escape_chars,
    output qsu_pkg::phase_t               phase_next,
    output logic [1:0]                    hex_seen_next,
    output logic [15:0]                   code_point_next,
    output qsu_pkg::group_t               group
);
    import qsu_pkg::*;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [3:0] SLOTS_MAX    = 4'(ESCAPE_SLOTS);

    typedef struct packed {
        logic    has;
        result_t res;
        phase_t  ph;
    } sb_t;

    function automatic logic [7:0] map_escape(input logic [7:0] b);
        logic [7:0] m;
        case (b)
            8'h61:   m = 8'h07;
            8'h62:   m = 8'h08;
            8'h66:   m = 8'h0c;
            8'h6e:   m = 8'h0a;
            8'h72:   m = 8'h0d;
            8'h74:   m = 8'h09;
            8'h76:   m = 8'h0b;
            default: m = b;
        endcase
        return m;
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b1, 4'(b - 8'h37)};
        end else begin
            v = 5'd0;
        end
        return v;
    endfunction

    function automatic sb_t string_byte(input logic [7:0] b, input logic esc_on);
        sb_t s;
        s.has = 1'b1;
        s.res = '{out_byte: 8'h00, status: ST_BYTE};
        s.ph  = PH_STRING;
        if (b < 8'h20 || b == 8'h7f) begin
            s.ph         = PH_IDLE;
            s.res.status = ST_CONTROL;
        end else if (b == CH_BACKSLASH && esc_on) begin
            s.has = 1'b0;
            s.ph  = PH_BACKSLASH;
        end else if (b == CH_QUOTE) begin
            s.ph         = PH_IDLE;
            s.res.status = ST_DONE;
        end else begin
            s.res.out_byte = b;
        end
        return s;
    endfunction

    logic [3:0]  active;
    logic        esc_on;
    logic        is_esc;
    logic [4:0]  hexv;
    logic [15:0] cp;
    sb_t         sb;

    always_comb begin
        active = (escape_count > SLOTS_MAX) ? SLOTS_MAX : escape_count;
        esc_on = (active != 4'd0);
        is_esc = esc_on && (text_byte == CH_QUOTE || text_byte == CH_BACKSLASH);
        for (int i = 0; i < ESCAPE_SLOTS; i++) begin
            if (4'(i) < active && escape_chars[8*i +: 8] == text_byte) begin
                is_esc = 1'b1;
            end
        end
        hexv = hex_value(text_byte);
        cp   = {code_point[11:0], hexv[3:0]};
        sb   = string_byte(text_byte, esc_on);

        group           = '0;
        phase_next      = phase;
        hex_seen_next   = hex_seen;
        code_point_next = code_point;

        unique case (phase)
            PH_IDLE: begin
                if (text_byte == CH_QUOTE) begin
                    phase_next = PH_STRING;
                end else begin
                    group.count  = 2'd1;
                    group.slot[0] = '{out_byte: 8'h00, status: ST_NOT_STRING};
                end
            end
            PH_STRING: begin
                phase_next    = sb.ph;
                group.count   = {1'b0, sb.has};
                group.slot[0] = sb.res;
            end
            PH_BACKSLASH: begin
                if (is_esc) begin
                    if (text_byte == CH_U) begin
                        phase_next      = PH_UNICODE;
                        hex_seen_next   = 2'd0;
                        code_point_next = 16'h0000;
                        if (final_byte) begin
                            phase_next    = PH_IDLE;
                            group.count   = 2'd1;
                            group.slot[0] = '{out_byte: 8'h00, status: ST_TRUNCATED};
                        end
                    end else begin
                        phase_next    = PH_STRING;
                        group.count   = 2'd1;
                        group.slot[0] = '{out_byte: map_escape(text_byte), status: ST_BYTE};
                    end
                end else begin
                    phase_next    = sb.ph;
                    group.count   = sb.has ? 2'd2 : 2'd1;
                    group.slot[0] = '{out_byte: CH_BACKSLASH, status: ST_BYTE};
                    group.slot[1] = sb.res;
                end
            end
            PH_UNICODE: begin
                if (final_byte && hex_seen != 2'd3) begin
                    phase_next    = PH_IDLE;
                    group.count   = 2'd1;
                    group.slot[0] = '{out_byte: 8'h00, status: ST_TRUNCATED};
                end else if (!hexv[4]) begin
                    phase_next    = PH_IDLE;
                    group.count   = 2'd1;
                    group.slot[0] = '{out_byte: 8'h00, status: ST_BAD_HEX};
                end else if (hex_seen == 2'd3) begin
                    hex_seen_next   = 2'd0;
                    code_point_next = 16'h0000;
                    phase_next      = PH_STRING;
                    if (cp <= 16'h007f) begin
                        group.count   = 2'd1;
                        group.slot[0] = '{out_byte: cp[7:0], status: ST_BYTE};
                    end else if (cp <= 16'h07ff) begin
                        group.count   = 2'd2;
                        group.slot[0] = '{out_byte: 8'hc0 | {3'b000, cp[10:6]},
                                          status: ST_BYTE};
                        group.slot[1] = '{out_byte: 8'h80 | {2'b00, cp[5:0]},
                                          status: ST_BYTE};
                    end else if (cp >= 16'hd800 && cp <= 16'hdfff) begin
                        phase_next    = PH_IDLE;
                        group.count   = 2'd1;
                        group.slot[0] = '{out_byte: 8'h00, status: ST_SURROGATE};
                    end else begin
                        group.count   = 2'd3;
                        group.slot[0] = '{out_byte: 8'he0 | {4'b0000, cp[15:12]},
                                          status: ST_BYTE};
                        group.slot[1] = '{out_byte: 8'h80 | {2'b00, cp[11:6]},
                                          status: ST_BYTE};
                        group.slot[2] = '{out_byte: 8'h80 | {2'b00, cp[5:0]},
                                          status: ST_BYTE};
                    end
                end else begin
                    hex_seen_next   = hex_seen + 2'd1;
                    code_point_next = cp;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        // An input that ends with the string still open voids what it decoded.
        if (final_byte && phase_next != PH_IDLE) begin
            group       = '0;
            group.count = 2'd1;
            group.slot[0] = '{out_byte: 8'h00, status: ST_UNTERMINATED};
        end
        if (final_byte || phase_next == PH_IDLE) begin
            phase_next      = PH_IDLE;
            hex_seen_next   = 2'd0;
            code_point_next = 16'h0000;
        end
    end

endmodule

### src/qsu_out_buffer.sv
// ---------------------------------------------------------------------------
// Quoted string unescaper result buffer
// Holds the result group of one text byte and hands it out one result a cycle while the result side is ready.
// ---------------------------------------------------------------------------
module qsu_out_buffer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  qsu_pkg::group_t group,
    output logic            can_load,
    output logic            result_valid,
    input  logic            result_ready,
    output logic [7:0]      out_byte,
    output logic [2:0]      status,
    output logic            last_of_run
);
    import qsu_pkg::*;

    `include "quoted_string_unescape_utf8_assert.svh"

    group_t     grp_reg;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       valid_reg;
    logic       valid_next;
    logic       is_last;
    logic       drain_last;
    result_t    cur;

    always_comb begin
        cur        = grp_reg.slot[idx_reg];
        is_last    = (idx_reg == grp_reg.count - 2'd1);
        drain_last = valid_reg && result_ready && is_last;
        can_load   = !valid_reg || drain_last;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end else if (valid_reg && result_ready) begin
            if (is_last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            grp_reg <= group;
        end
    end

    assign result_valid = valid_reg;
    assign out_byte     = cur.out_byte;
    assign status       = cur.status;
    assign last_of_run  = is_last;

    `QSU_ASSERT_SAME(a_idx_in_group, valid_reg, idx_reg < grp_reg.count,
        "result index beyond its group")
    `QSU_ASSERT_SAME(a_group_not_empty, valid_reg, grp_reg.count != 2'd0,
        "empty result group held in buffer")
    `QSU_ASSERT_NEXT(a_load_starts_group, load, valid_reg && idx_reg == 2'd0,
        "loaded group does not start at its first result")

endmodule

### src/quoted_string_unescape_utf8.sv
// ---------------------------------------------------------------------------
// Quoted string unescaper with UTF-8 output
// Scans one quoted string a byte at a time, resolves backslash and \u escapes
// and delivers decoded bytes and status codes.
//
//   channel   handshake                    payload
//   text      text_valid / text_ready      text_byte, final_byte
//   result    result_valid / result_ready  out_byte, status, last_of_run
//   config    cfg_write                    cfg_index, cfg_data
//
// A text byte is decoded in the cycle after it is taken and can be followed
// by another in the next cycle. Its up to three results leave one per cycle
// from the result buffer while the result side is ready; a byte that gives
// results waits in the input register until the buffer takes them. A stalled
// result side stops text intake once the input and result registers are full.
// Reset puts the scanner in idle and the escape registers at their default values.
// ---------------------------------------------------------------------------
module quoted_string_unescape_utf8 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           text_valid,
    output logic                           text_ready,
    input  logic [7:0]                     text_byte,
    input  logic                           final_byte,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [7:0]                     out_byte,
    output logic [2:0]                     status,
    output logic                           last_of_run,
    input  logic                           cfg_write,
    input  logic [0:0]                     cfg_index,
    input  logic [qsu_pkg::CFG_DATA_W-1:0] cfg_data
);
    import qsu_pkg::*;

    `include "quoted_string_unescape_utf8_assert.svh"

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_fin_reg;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [1:0]            hex_seen_reg;
    logic [1:0]            hex_seen_next;
    logic [15:0]           code_point_reg;
    logic [15:0]           code_point_next;
    logic [3:0]            escape_count_reg;
    logic [CFG_DATA_W-1:0] escape_chars_reg;
    group_t                group;
    logic                  can_load;
    logic                  advance;
    logic                  load;

    qsu_decode u_decode (
        .text_byte       (in_byte_reg),
        .final_byte      (in_fin_reg),
        .phase           (phase_reg),
        .hex_seen        (hex_seen_reg),
        .code_point      (code_point_reg),
        .escape_count    (escape_count_reg),
        .escape_chars    (escape_chars_reg),
        .phase_next      (phase_next),
        .hex_seen_next   (hex_seen_next),
        .code_point_next (code_point_next),
        .group           (group)
    );

    qsu_out_buffer u_out_buffer (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .group        (group),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .status       (status),
        .last_of_run  (last_of_run)
    );

    assign advance    = in_valid_reg && (group.count == 2'd0 || can_load);
    assign load       = in_valid_reg && group.count != 2'd0 && can_load;
    assign text_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (text_valid && text_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (text_valid && text_ready) begin
            in_byte_reg <= text_byte;
            in_fin_reg  <= final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg      <= PH_IDLE;
            hex_seen_reg   <= 2'd0;
            code_point_reg <= 16'h0000;
        end else if (advance) begin
            phase_reg      <= phase_next;
            hex_seen_reg   <= hex_seen_next;
            code_point_reg <= code_point_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            escape_count_reg <= ESCAPE_COUNT_RESET;
            escape_chars_reg <= ESCAPE_CHARS_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_ESCAPE_COUNT: escape_count_reg <= cfg_data[3:0];
                CFG_ESCAPE_CHARS: escape_chars_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    `QSU_ASSERT_SAME(a_hex_only_in_unicode, hex_seen_reg != 2'd0,
        phase_reg == PH_UNICODE, "hex digit count set outside a unicode escape")
    `QSU_ASSERT_SAME(a_cp_only_in_unicode, code_point_reg != 16'h0000,
        phase_reg == PH_UNICODE, "code point set outside a unicode escape")
    `QSU_ASSERT_NEXT(a_final_returns_idle, advance && in_fin_reg,
        phase_reg == PH_IDLE, "scanner not idle after the final byte")

endmodule
